>>> rtl/core/brs_pkg.sv
// Shared widths, constants and types of the biquadratic root solver.
package brs_pkg;

  localparam int CoefIntW = 17;
  localparam int MagAW    = 16;
  localparam int ProdBW   = 34;
  localparam int DiscW    = 37;
  localparam int DiscKeepW = 33;
  localparam int Rad1W    = 50;
  localparam int Sq1W     = Rad1W / 2;
  localparam int NumW     = 27;
  localparam int MagNW    = 26;
  localparam int ScaleW   = 21;
  localparam int ProdW    = 47;
  localparam int Rad2W    = 48;
  localparam int Sq2W     = Rad2W / 2;
  localparam int MagRootW = 15;
  localparam int RootW    = 16;
  localparam int CountW   = 3;

  localparam logic [ScaleW-1:0]   SCALE    = 21'd1280000;
  localparam logic [MagRootW-1:0] ROOT_MAX = 15'd32767;
  localparam logic [Sq2W:0]       ROUND_HALF = 25'd128;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_A_ZERO    = 2'd1,
    ST_DISC_NEG  = 2'd2,
    ST_NO_SQUARE = 2'd3
  } status_t;

  typedef struct packed {
    logic a_zero;
    logic disc_neg;
  } flags_t;

  localparam logic [CountW-1:0] CNT_ZERO  = 3'd0;
  localparam logic [CountW-1:0] CNT_ONE   = 3'd1;
  localparam logic [CountW-1:0] CNT_TWO   = 3'd2;
  localparam logic [CountW-1:0] CNT_THREE = 3'd3;
  localparam logic [CountW-1:0] CNT_FOUR  = 3'd4;

endpackage

>>> rtl/core/brs_isqrt_pipe.sv
// Pipelined integer square root, one result bit per stage, with sideband payload.
module brs_isqrt_pipe #(
  parameter int IW    = 50,
  parameter int LANES = 1,
  parameter int PW    = 1,
  localparam int OW   = IW / 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_vld,
  input  logic [LANES-1:0][IW-1:0]      in_rad,
  input  logic [PW-1:0]                 in_pay,
  output logic                          out_vld,
  output logic [LANES-1:0][OW-1:0]      out_root,
  output logic [PW-1:0]                 out_pay
);

  wire [LANES-1:0][IW-1:0] st_rad  [OW+1];
  wire [LANES-1:0][OW+1:0] st_rem  [OW+1];
  wire [LANES-1:0][OW-1:0] st_root [OW+1];
  wire [PW-1:0]            st_pay  [OW+1];
  wire                     st_vld  [OW+1];

  assign st_rad[0]  = in_rad;
  assign st_rem[0]  = '0;
  assign st_root[0] = '0;
  assign st_pay[0]  = in_pay;
  assign st_vld[0]  = in_vld;

  for (genvar k = 0; k < OW; k++) begin : gen_stage
    logic          vld_r;
    logic [PW-1:0] pay_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (adv) begin
        vld_r <= st_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pay_r <= st_pay[k];
      end
    end

    assign st_vld[k+1] = vld_r;
    assign st_pay[k+1] = pay_r;

    for (genvar l = 0; l < LANES; l++) begin : gen_lane
      logic [IW-1:0] rad_r, rad_nxt;
      logic [OW+1:0] rem_r, rem_nxt;
      logic [OW-1:0] root_r, root_nxt;
      logic [OW+1:0] sh;
      logic [OW+1:0] trial;

      always_comb begin
        sh      = {st_rem[k][l][OW-1:0], st_rad[k][l][IW-1 -: 2]};
        trial   = {st_root[k][l], 2'b01};
        rad_nxt = {st_rad[k][l][IW-3:0], 2'b00};
        if (sh >= trial) begin
          rem_nxt  = sh - trial;
          root_nxt = {st_root[k][l][OW-2:0], 1'b1};
        end else begin
          rem_nxt  = sh;
          root_nxt = {st_root[k][l][OW-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          rad_r  <= rad_nxt;
          rem_r  <= rem_nxt;
          root_r <= root_nxt;
        end
      end

      assign st_rad[k+1][l]  = rad_r;
      assign st_rem[k+1][l]  = rem_r;
      assign st_root[k+1][l] = root_r;
    end
  end

  assign out_vld  = st_vld[OW];
  assign out_root = st_root[OW];
  assign out_pay  = st_pay[OW];

endmodule

>>> rtl/core/brs_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, shared divisor across lanes.
module brs_div_pipe #(
  parameter int NW    = 47,
  parameter int DW    = 16,
  parameter int LANES = 2,
  parameter int PW    = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_vld,
  input  logic [LANES-1:0][NW-1:0] in_num,
  input  logic [DW-1:0]            in_den,
  input  logic [PW-1:0]            in_pay,
  output logic                     out_vld,
  output logic [LANES-1:0][NW-1:0] out_quo,
  output logic [PW-1:0]            out_pay
);

  wire [LANES-1:0][NW-1:0] st_num [NW+1];
  wire [LANES-1:0][DW-1:0] st_rem [NW+1];
  wire [DW-1:0]            st_den [NW+1];
  wire [PW-1:0]            st_pay [NW+1];
  wire                     st_vld [NW+1];

  assign st_num[0] = in_num;
  assign st_rem[0] = '0;
  assign st_den[0] = in_den;
  assign st_pay[0] = in_pay;
  assign st_vld[0] = in_vld;

  for (genvar k = 0; k < NW; k++) begin : gen_stage
    logic          vld_r;
    logic [PW-1:0] pay_r;
    logic [DW-1:0] den_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (adv) begin
        vld_r <= st_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pay_r <= st_pay[k];
        den_r <= st_den[k];
      end
    end

    assign st_vld[k+1] = vld_r;
    assign st_pay[k+1] = pay_r;
    assign st_den[k+1] = den_r;

    for (genvar l = 0; l < LANES; l++) begin : gen_lane
      logic [NW-1:0] num_r, num_nxt;
      logic [DW-1:0] rem_r, rem_nxt;
      logic [DW:0]   sh;
      logic [DW:0]   diff;

      always_comb begin
        sh   = {st_rem[k][l], st_num[k][l][NW-1]};
        diff = sh - {1'b0, st_den[k]};
        if (sh >= {1'b0, st_den[k]}) begin
          rem_nxt = diff[DW-1:0];
          num_nxt = {st_num[k][l][NW-2:0], 1'b1};
        end else begin
          rem_nxt = sh[DW-1:0];
          num_nxt = {st_num[k][l][NW-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          num_r <= num_nxt;
          rem_r <= rem_nxt;
        end
      end

      assign st_num[k+1][l] = num_r;
      assign st_rem[k+1][l] = rem_r;
    end
  end

  assign out_vld = st_vld[NW];
  assign out_quo = st_num[NW];
  assign out_pay = st_pay[NW];

endmodule

>>> rtl/core/biquadratic_root_solver_top.sv
// Top level of the pipelined biquadratic root solver.
//
// Solves a*x^4 + b*x^2 + c = 0 for coefficients in signed Q8.8.
// Input channel: in_valid / in_stall with in_coef_a, in_coef_b, in_coef_c.
// Result channel: out_valid / out_stall with status, distinct root count
// and up to four roots in ascending order, in hundredths; unused roots are 0.
// A transfer happens on a rising edge with valid high and stall low.
//
// Throughput: one equation per cycle, sustained, as long as the result side
// takes transfers. The pipeline depth is set by three bit-serial pipelines:
// a 25-stage square root of the discriminant, a 47-stage divider for the two
// squares and a 24-stage square root for the roots, plus eight stages of
// setup, rounding and sort.
//
// The whole pipeline advances as one when the output register is empty or
// is being taken; while a result waits under out_stall, every stage holds
// and in_stall is raised, so nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; data registers
// keep whatever they hold and are ignored until valid returns.
module biquadratic_root_solver_top
  import brs_pkg::*;
#(
  parameter int COEF_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [15:0]       in_coef_a,
  input  logic signed [15:0]       in_coef_b,
  input  logic signed [15:0]       in_coef_c,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_status,
  output logic [CountW-1:0]        out_root_count,
  output logic signed [RootW-1:0]  out_root_first,
  output logic signed [RootW-1:0]  out_root_second,
  output logic signed [RootW-1:0]  out_root_third,
  output logic signed [RootW-1:0]  out_root_fourth
);

  // Global advance: hold everything only while a finished result is stalled.
  logic adv;
  logic out_valid_r;
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // Coefficient extraction: low COEF_WIDTH bits as two's complement, or a
  // zero-extended field when the configured width exceeds the port.
  logic signed [CoefIntW-1:0] ext_a, ext_b, ext_c;
  if (COEF_WIDTH > 16) begin : gen_zext
    assign ext_a = {1'b0, in_coef_a};
    assign ext_b = {1'b0, in_coef_b};
    assign ext_c = {1'b0, in_coef_c};
  end else begin : gen_sext
    assign ext_a = CoefIntW'($signed(in_coef_a[COEF_WIDTH-1:0]));
    assign ext_b = CoefIntW'($signed(in_coef_b[COEF_WIDTH-1:0]));
    assign ext_c = CoefIntW'($signed(in_coef_c[COEF_WIDTH-1:0]));
  end

  // Stage 1: capture coefficients.
  logic                       v1_r;
  logic signed [CoefIntW-1:0] a1_r, b1_r, c1_r;

  // Stage 2: products b*b and a*c.
  logic                       v2_r;
  logic signed [ProdBW-1:0]   bb2_r, ac2_r;
  logic signed [CoefIntW-1:0] a2_r, b2_r;

  // Stage 3: discriminant and early status flags.
  logic                       v3_r;
  logic signed [DiscW-1:0]    disc3_r, disc3_nxt;
  logic signed [CoefIntW-1:0] a3_r, b3_r;
  flags_t                     fl3_r, fl3_nxt;

  always_comb begin
    disc3_nxt       = DiscW'(bb2_r) - (DiscW'(ac2_r) <<< 2);
    fl3_nxt.a_zero  = (a2_r == '0);
    fl3_nxt.disc_neg = disc3_nxt[DiscW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_r    <= ext_a;
      b1_r    <= ext_b;
      c1_r    <= ext_c;
      bb2_r   <= b1_r * b1_r;
      ac2_r   <= a1_r * c1_r;
      a2_r    <= a1_r;
      b2_r    <= b1_r;
      disc3_r <= disc3_nxt;
      a3_r    <= a2_r;
      b3_r    <= b2_r;
      fl3_r   <= fl3_nxt;
    end
  end

  // Square root of the discriminant scaled by 2^16.
  localparam int Pay1W = $bits(flags_t) + 2 * CoefIntW;
  logic [0:0][Rad1W-1:0] rad1;
  logic [Pay1W-1:0]      pay1_in, pay1_out;
  logic [0:0][Sq1W-1:0]  sq1;
  logic                  v_sq1;

  assign rad1[0] = {1'b0, disc3_r[DiscKeepW-1:0], 16'd0};
  assign pay1_in = {fl3_r, a3_r, b3_r};

  brs_isqrt_pipe #(
    .IW    (Rad1W),
    .LANES (1),
    .PW    (Pay1W)
  ) u_sqrt_disc (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (v3_r),
    .in_rad   (rad1),
    .in_pay   (pay1_in),
    .out_vld  (v_sq1),
    .out_root (sq1),
    .out_pay  (pay1_out)
  );

  flags_t                     fl_s;
  logic signed [CoefIntW-1:0] a_s, b_s;
  assign {fl_s, a_s, b_s} = pay1_out;

  // Stage 4: numerators -256*b +- R.
  logic                       v4_r;
  logic signed [NumW-1:0]     n1_4_r, n2_4_r, base4;
  logic signed [CoefIntW-1:0] a4_r;
  flags_t                     fl4_r;

  assign base4 = -(NumW'(b_s) <<< 8);

  // Stage 5: sign checks and magnitudes.
  logic                       v5_r;
  logic [MagNW-1:0]           m1_5_r, m2_5_r;
  logic [MagAW-1:0]           ma5_r;
  logic                       neg1_5_r, neg2_5_r;
  flags_t                     fl5_r;
  logic signed [NumW-1:0]     n1_abs, n2_abs;
  logic signed [CoefIntW-1:0] a_abs;

  assign n1_abs = n1_4_r[NumW-1] ? -n1_4_r : n1_4_r;
  assign n2_abs = n2_4_r[NumW-1] ? -n2_4_r : n2_4_r;
  assign a_abs  = a4_r[CoefIntW-1] ? -a4_r : a4_r;

  // Stage 6: scale numerators by 10000 * 128.
  logic                  v6_r;
  logic [ProdW-1:0]      p1_6_r, p2_6_r;
  logic [MagAW-1:0]      ma6_r;
  logic                  neg1_6_r, neg2_6_r;
  flags_t                fl6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v_sq1;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n1_4_r   <= base4 + NumW'({1'b0, sq1[0]});
      n2_4_r   <= base4 - NumW'({1'b0, sq1[0]});
      a4_r     <= a_s;
      fl4_r    <= fl_s;
      m1_5_r   <= n1_abs[MagNW-1:0];
      m2_5_r   <= n2_abs[MagNW-1:0];
      ma5_r    <= a_abs[MagAW-1:0];
      neg1_5_r <= (n1_4_r != '0) && (n1_4_r[NumW-1] != a4_r[CoefIntW-1]);
      neg2_5_r <= (n2_4_r != '0) && (n2_4_r[NumW-1] != a4_r[CoefIntW-1]);
      fl5_r    <= fl4_r;
      p1_6_r   <= m1_5_r * SCALE;
      p2_6_r   <= m2_5_r * SCALE;
      ma6_r    <= ma5_r;
      neg1_6_r <= neg1_5_r;
      neg2_6_r <= neg2_5_r;
      fl6_r    <= fl5_r;
    end
  end

  // Divide both scaled numerators by |a|.
  localparam int Pay2W = $bits(flags_t) + 2;
  logic [1:0][ProdW-1:0] div_num, quo;
  logic [Pay2W-1:0]      pay2_in, pay2_out, pay3_out;
  logic                  v_div;

  assign div_num = {p2_6_r, p1_6_r};
  assign pay2_in = {fl6_r, neg2_6_r, neg1_6_r};

  brs_div_pipe #(
    .NW    (ProdW),
    .DW    (MagAW),
    .LANES (2),
    .PW    (Pay2W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (v6_r),
    .in_num  (div_num),
    .in_den  (ma6_r),
    .in_pay  (pay2_in),
    .out_vld (v_div),
    .out_quo (quo),
    .out_pay (pay2_out)
  );

  // Square root of each quotient.
  logic [1:0][Rad2W-1:0] rad2;
  logic [1:0][Sq2W-1:0]  sq2;
  logic                  v_sq2;

  assign rad2 = {{1'b0, quo[1]}, {1'b0, quo[0]}};

  brs_isqrt_pipe #(
    .IW    (Rad2W),
    .LANES (2),
    .PW    (Pay2W)
  ) u_sqrt_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (v_div),
    .in_rad   (rad2),
    .in_pay   (pay2_out),
    .out_vld  (v_sq2),
    .out_root (sq2),
    .out_pay  (pay3_out)
  );

  // Stage 7: round to hundredths and saturate.
  flags_t               fl_q;
  logic                 neg1_q, neg2_q;
  logic [Sq2W:0]        rs1, rs2;
  logic [Sq2W-8:0]      r1, r2;
  logic                 v7_r;
  logic [MagRootW-1:0]  n1_7_r, n2_7_r;
  logic                 ok1_7_r, ok2_7_r;
  flags_t               fl7_r;

  assign {fl_q, neg2_q, neg1_q} = pay3_out;
  assign rs1 = {1'b0, sq2[0]} + ROUND_HALF;
  assign rs2 = {1'b0, sq2[1]} + ROUND_HALF;
  assign r1  = rs1[Sq2W:8];
  assign r2  = rs2[Sq2W:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (adv) begin
      v7_r <= v_sq2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n1_7_r  <= (r1 > (Sq2W-7)'(ROOT_MAX)) ? ROOT_MAX : r1[MagRootW-1:0];
      n2_7_r  <= (r2 > (Sq2W-7)'(ROOT_MAX)) ? ROOT_MAX : r2[MagRootW-1:0];
      ok1_7_r <= !neg1_q;
      ok2_7_r <= !neg2_q;
      fl7_r   <= fl_q;
    end
  end

  // Output stage: dedupe and order the roots +-lo, +-hi.
  logic [MagRootW-1:0]     lo, hi;
  logic signed [RootW-1:0] lo_p, hi_p;
  status_t                 status_nxt, status_r;
  logic [CountW-1:0]       count_nxt, count_r;
  logic signed [RootW-1:0] r_nxt [4];
  logic signed [RootW-1:0] r_r   [4];

  always_comb begin
    if (ok1_7_r && ok2_7_r) begin
      lo = (n1_7_r < n2_7_r) ? n1_7_r : n2_7_r;
      hi = (n1_7_r < n2_7_r) ? n2_7_r : n1_7_r;
    end else if (ok1_7_r) begin
      lo = n1_7_r;
      hi = n1_7_r;
    end else begin
      lo = n2_7_r;
      hi = n2_7_r;
    end
    lo_p = RootW'({1'b0, lo});
    hi_p = RootW'({1'b0, hi});
    status_nxt = ST_OK;
    count_nxt  = CNT_ZERO;
    for (int i = 0; i < 4; i++) begin
      r_nxt[i] = '0;
    end
    if (fl7_r.a_zero) begin
      status_nxt = ST_A_ZERO;
    end else if (fl7_r.disc_neg) begin
      status_nxt = ST_DISC_NEG;
    end else if (!ok1_7_r && !ok2_7_r) begin
      status_nxt = ST_NO_SQUARE;
    end else if (lo == hi) begin
      if (lo == '0) begin
        count_nxt = CNT_ONE;
      end else begin
        count_nxt = CNT_TWO;
        r_nxt[0]  = -hi_p;
        r_nxt[1]  = hi_p;
      end
    end else if (lo == '0) begin
      count_nxt = CNT_THREE;
      r_nxt[0]  = -hi_p;
      r_nxt[2]  = hi_p;
    end else begin
      count_nxt = CNT_FOUR;
      r_nxt[0]  = -hi_p;
      r_nxt[1]  = -lo_p;
      r_nxt[2]  = lo_p;
      r_nxt[3]  = hi_p;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status_r <= status_nxt;
      count_r  <= count_nxt;
      for (int i = 0; i < 4; i++) begin
        r_r[i] <= r_nxt[i];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_root_count  = count_r;
  assign out_root_first  = r_r[0];
  assign out_root_second = r_r[1];
  assign out_root_third  = r_r[2];
  assign out_root_fourth = r_r[3];

`ifndef SYNTHESIS
  a_fail_no_roots: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != ST_OK) |-> (count_r == CNT_ZERO) && (r_r[0] == '0))
    else $error("failure status with roots reported");

  a_ok_has_roots: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == ST_OK) |-> (count_r != CNT_ZERO) && (count_r <= CNT_FOUR))
    else $error("solved equation with bad root count");

  a_four_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (count_r == CNT_FOUR) |->
      (r_r[0] < r_r[1]) && (r_r[1] < r_r[2]) && (r_r[2] < r_r[3]))
    else $error("four roots not strictly ascending");

  a_pair_symmetric: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (count_r == CNT_TWO) |-> (r_r[0] == -r_r[1]) && (r_r[1] > 0))
    else $error("root pair not symmetric");
`endif

endmodule

>>> test/tb_biquadratic_root_solver_top.sv
// Testbench for the biquadratic root solver: directed and random equations checked against a predictor.
`timescale 1ns / 100ps

module tb_biquadratic_root_solver_top;
  import brs_pkg::*;

  typedef struct {
    status_t      status;
    logic [2:0]   count;
    logic [15:0]  root [4];
  } solution_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_coef_a = '0;
  logic signed [15:0] in_coef_b = '0;
  logic signed [15:0] in_coef_c = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [1:0] out_status;
  logic [2:0] out_root_count;
  logic signed [15:0] out_root_first, out_root_second, out_root_third, out_root_fourth;

  solution_t pending_solutions[$];
  int mismatches = 0;
  longint cycle_count = 0;
  bit stall_enable = 1'b1;

  // Period 2 ns.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  biquadratic_root_solver_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_coef_a(in_coef_a), .in_coef_b(in_coef_b), .in_coef_c(in_coef_c),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_root_count(out_root_count),
    .out_root_first(out_root_first), .out_root_second(out_root_second),
    .out_root_third(out_root_third), .out_root_fourth(out_root_fourth)
  );

  // Integer square root, floor.
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Root magnitude in hundredths for the square num/(512*a); returns 0 if negative.
  function automatic bit square_root_hundredths(longint num, longint a, output longint mag);
    longint unsigned mn, ma, t, n;
    mag = 0;
    if (num != 0 && ((num < 0) != (a < 0))) return 1'b0;
    mn = num < 0 ? -num : num;
    ma = a < 0 ? -a : a;
    t = mn * 64'd1280000 / ma;
    n = (int_sqrt(t) + 128) >> 8;
    if (n > 32767) n = 32767;
    mag = n;
    return 1'b1;
  endfunction

  function automatic solution_t solve_biquadratic(logic signed [15:0] ca, cb, cc);
    solution_t s;
    longint a, b, c, disc, r, base, n;
    longint cand[4];
    longint uniq[4];
    int ncand, nuniq, j;
    bit seen;
    a = ca; b = cb; c = cc;
    s.status = ST_OK;
    s.count = '0;
    for (int i = 0; i < 4; i++) s.root[i] = '0;
    ncand = 0;
    nuniq = 0;
    if (a == 0) begin
      s.status = ST_A_ZERO;
    end else begin
      disc = b * b - 4 * a * c;
      if (disc < 0) begin
        s.status = ST_DISC_NEG;
      end else begin
        r = int_sqrt(disc << 16);
        base = -(b * 256);
        if (square_root_hundredths(base + r, a, n)) begin
          cand[ncand++] = n;
          cand[ncand++] = -n;
        end
        if (square_root_hundredths(base - r, a, n)) begin
          cand[ncand++] = n;
          cand[ncand++] = -n;
        end
        if (ncand == 0) s.status = ST_NO_SQUARE;
      end
    end
    // Insert each distinct root into an ascending list.
    for (int i = 0; i < ncand; i++) begin
      seen = 1'b0;
      for (int k = 0; k < nuniq; k++) if (uniq[k] == cand[i]) seen = 1'b1;
      if (!seen) begin
        j = nuniq;
        while (j > 0 && uniq[j-1] > cand[i]) begin
          uniq[j] = uniq[j-1];
          j--;
        end
        uniq[j] = cand[i];
        nuniq++;
      end
    end
    s.count = nuniq[2:0];
    for (int i = 0; i < nuniq; i++) s.root[i] = uniq[i][15:0];
    return s;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Send one equation: idle a random gap, then hold valid until the transfer.
  // Valid stays high after the transfer so back-to-back items need no gap.
  task automatic send_equation(logic signed [15:0] a, b, c);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_coef_a <= a;
    in_coef_b <= b;
    in_coef_c <= c;
    pending_solutions.push_back(solve_biquadratic(a, b, c));
    do @(posedge clk); while (in_stall);
  endtask

  // Result side: draw a stall length per result; sometimes run with no stalls.
  initial begin
    int hold;
    @(posedge clk iff rst_n);
    forever begin
      hold = stall_enable ? $urandom_range(0, 9) : 0;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk iff out_valid);
    end
  end

  // Compare every result transfer with the oldest expected solution.
  always @(posedge clk) begin
    solution_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_solutions.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_solutions.pop_front();
        if (out_status != want.status) report_mismatch("status", out_status, want.status);
        if (out_root_count != want.count)
          report_mismatch("root_count", out_root_count, want.count);
        if (out_root_first != want.root[0])
          report_mismatch("root_first", out_root_first, $signed(want.root[0]));
        if (out_root_second != want.root[1])
          report_mismatch("root_second", out_root_second, $signed(want.root[1]));
        if (out_root_third != want.root[2])
          report_mismatch("root_third", out_root_third, $signed(want.root[2]));
        if (out_root_fourth != want.root[3])
          report_mismatch("root_fourth", out_root_fourth, $signed(want.root[3]));
      end
    end
  end

  // Drop the run at a generous limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 200000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Corners: zero a, negative discriminant, zero discriminant, squares of each sign.
  task automatic test_directed();
    send_equation(16'sd0, 16'sd256, 16'sd256);
    send_equation(16'sd256, 16'sd0, 16'sd256);
    send_equation(16'sd256, -16'sd512, 16'sd256);
    send_equation(16'sd256, 16'sd512, 16'sd256);
    send_equation(16'sd256, 16'sd1280, 16'sd1024);
    send_equation(16'sd256, -16'sd1280, 16'sd1024);
    send_equation(16'sd256, 16'sd0, -16'sd1024);
    send_equation(16'sd256, 16'sd0, 16'sd0);
    send_equation(16'sd256, -16'sd256, 16'sd0);
    send_equation(-16'sd256, 16'sd1280, -16'sd1024);
    send_equation(16'sd1, -16'sd32768, 16'sd0);
    send_equation(16'sd1, 16'sd32767, -16'sd32768);
    send_equation(-16'sd32768, -16'sd32768, -16'sd32768);
    send_equation(16'sd32767, 16'sd32767, 16'sd32767);
    send_equation(-16'sd1, 16'sd0, 16'sd32767);
    send_equation(16'sd32767, 16'sd0, -16'sd32768);
    send_equation(16'sd1, 16'sd0, -16'sd1);
    send_equation(-16'sd1, -16'sd1, -16'sd1);
    send_equation(16'sd0, 16'sd0, 16'sd0);
    send_equation(16'sd1, 16'sd1, 16'sd1);
  endtask

  // Random: one in four equations built from chosen squares, the rest random coefficients.
  task automatic test_random(int n);
    logic signed [15:0] a, b, c;
    int p, q;
    for (int i = 0; i < n; i++) begin
      stall_enable = (i % 400) < 300;
      case ($urandom_range(0, 3))
        0: begin
          a = 16'($urandom);
          b = 16'($urandom);
          c = 16'($urandom);
        end
        1: begin
          // a (x^2 - p)(x^2 - q) with small integer squares.
          p = $signed($urandom_range(0, 10)) - 5;
          q = $signed($urandom_range(0, 10)) - 5;
          a = 16'($urandom_range(1, 4) * 256);
          if ($urandom_range(0, 1)) a = -a;
          b = 16'(-(a * (p + q)));
          c = 16'(a * p * q);
        end
        2: begin
          a = 16'($signed($urandom_range(0, 511)) - 256);
          b = 16'($signed($urandom_range(0, 8191)) - 4096);
          c = 16'($signed($urandom_range(0, 8191)) - 4096);
        end
        default: begin
          a = $urandom_range(0, 3) == 0 ? 16'sd0 : $signed(16'($urandom));
          b = 16'($urandom);
          c = $urandom_range(0, 1) ? 16'sd0 : $signed(16'($urandom));
        end
      endcase
      send_equation(a, b, c);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1830);
    in_valid <= 1'b0;
    wait (pending_solutions.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
